FILE: hdl/aabb_xf_pkg.sv
package aabb_xf_pkg;

  localparam int FRAC_BITS = 8;
  localparam int NUM_ROWS  = 3;
  localparam int NUM_AXES  = 3;
  localparam int COEF_W    = 16;
  localparam int ROW_W     = 4 * COEF_W;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int ADDR_W    = 5;

  typedef logic signed [COEF_W-1:0] q88_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [ROW_W-1:0]         row_t;

  typedef enum logic [1:0] {
    REG_ROW_X = 2'd0,
    REG_ROW_Y = 2'd1,
    REG_ROW_Z = 2'd2
  } reg_idx_t;

  localparam row_t ROW_X_RESET = 64'h0000_0001_0000_0000;
  localparam row_t ROW_Y_RESET = 64'h0000_0000_0100_0000;
  localparam row_t ROW_Z_RESET = 64'h0000_0000_0001_0000;

  localparam q88_t Q_MAX = 16'sh7FFF;
  localparam q88_t Q_MIN = -16'sh8000;

endpackage

FILE: hdl/aabb_affine_transform.sv
// One box per cycle while out_stall is low; four registered stages (order,
// multiply, sum, shift/saturate), each with its own valid so bubbles are
// squeezed out.
// Reset (rst, synchronous, active high) clears the pipeline valids and
// restores the three coefficient rows to their reset values.
module aabb_affine_transform
  import aabb_xf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  q88_t              corner_a_x,
  input  q88_t              corner_a_y,
  input  q88_t              corner_a_z,
  input  q88_t              corner_b_x,
  input  q88_t              corner_b_y,
  input  q88_t              corner_b_z,
  output logic              out_valid,
  input  logic              out_stall,
  output q88_t              out_min_x,
  output q88_t              out_min_y,
  output q88_t              out_min_z,
  output q88_t              out_max_x,
  output q88_t              out_max_y,
  output q88_t              out_max_z,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [ROW_W-1:0]  pwdata,
  output logic [ROW_W-1:0]  prdata,
  output logic              pready
);

  row_t rows [NUM_ROWS];
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[REG_ROW_X] <= ROW_X_RESET;
      rows[REG_ROW_Y] <= ROW_Y_RESET;
      rows[REG_ROW_Z] <= ROW_Z_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_idx)
        REG_ROW_X: rows[REG_ROW_X] <= pwdata;
        REG_ROW_Y: rows[REG_ROW_Y] <= pwdata;
        REG_ROW_Z: rows[REG_ROW_Z] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ROW_X: prdata = rows[REG_ROW_X];
      REG_ROW_Y: prdata = rows[REG_ROW_Y];
      REG_ROW_Z: prdata = rows[REG_ROW_Z];
      default:   prdata = '0;
    endcase
  end

  // pipeline handshake
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !out_valid || !out_stall;
  assign rdy2     = !v3 || rdy3;
  assign rdy1     = !v2 || rdy2;
  assign in_stall = v1 && !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) v1        <= in_valid;
      if (rdy1)      v2        <= v1;
      if (rdy2)      v3        <= v2;
      if (rdy3)      out_valid <= v3;
    end
  end

  // stage 1: order each axis
  q88_t a_in [NUM_AXES];
  q88_t b_in [NUM_AXES];
  q88_t lo   [NUM_AXES];
  q88_t hi   [NUM_AXES];

  assign a_in[0] = corner_a_x;
  assign a_in[1] = corner_a_y;
  assign a_in[2] = corner_a_z;
  assign b_in[0] = corner_b_x;
  assign b_in[1] = corner_b_y;
  assign b_in[2] = corner_b_z;

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        lo[k] <= (a_in[k] < b_in[k]) ? a_in[k] : b_in[k];
        hi[k] <= (a_in[k] < b_in[k]) ? b_in[k] : a_in[k];
      end
    end
  end

  // stage 2: per-term extremes; coefficient sign picks the box edge
  prod_t pmin [NUM_ROWS][NUM_AXES];
  prod_t pmax [NUM_ROWS][NUM_AXES];
  prod_t pmin_next [NUM_ROWS][NUM_AXES];
  prod_t pmax_next [NUM_ROWS][NUM_AXES];

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        q88_t c;
        c = q88_t'(rows[r][COEF_W*k +: COEF_W]);
        if (c < 0) begin
          pmin_next[r][k] = PROD_W'(c) * PROD_W'(hi[k]);
          pmax_next[r][k] = PROD_W'(c) * PROD_W'(lo[k]);
        end else begin
          pmin_next[r][k] = PROD_W'(c) * PROD_W'(lo[k]);
          pmax_next[r][k] = PROD_W'(c) * PROD_W'(hi[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      pmin <= pmin_next;
      pmax <= pmax_next;
    end
  end

  // stage 3: sum with offset in Q18.16
  acc_t amin [NUM_ROWS];
  acc_t amax [NUM_ROWS];

  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        amin[r] <= ACC_W'(pmin[r][0]) + ACC_W'(pmin[r][1]) + ACC_W'(pmin[r][2])
                 + (ACC_W'(q88_t'(rows[r][3*COEF_W +: COEF_W])) <<< FRAC_BITS);
        amax[r] <= ACC_W'(pmax[r][0]) + ACC_W'(pmax[r][1]) + ACC_W'(pmax[r][2])
                 + (ACC_W'(q88_t'(rows[r][3*COEF_W +: COEF_W])) <<< FRAC_BITS);
      end
    end
  end

  // stage 4: floor shift and saturate
  function automatic q88_t shift_sat(acc_t v);
    logic signed [ACC_W-FRAC_BITS-1:0] s;
    s = v[ACC_W-1:FRAC_BITS];
    if (s > (ACC_W-FRAC_BITS)'(Q_MAX))      return Q_MAX;
    else if (s < (ACC_W-FRAC_BITS)'(Q_MIN)) return Q_MIN;
    else                                    return q88_t'(s);
  endfunction

  always_ff @(posedge clk) begin
    if (rdy3) begin
      out_min_x <= shift_sat(amin[0]);
      out_min_y <= shift_sat(amin[1]);
      out_min_z <= shift_sat(amin[2]);
      out_max_x <= shift_sat(amax[0]);
      out_max_y <= shift_sat(amax[1]);
      out_max_z <= shift_sat(amax[2]);
    end
  end

endmodule
